@@ hdl/lco_pkg.sv @@
// Shared constants and types for the label contour overlay block.
package lco_pkg;

  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int LABEL_BITS_DEF = 16;
  localparam int PIXEL_BITS_DEF = 16;

  localparam int VAL_BITS   = 16;
  localparam int ROW_W      = 12;
  localparam int FW_BITS    = 12;
  localparam int FH_BITS    = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_CONTOUR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT  = 2'd2;

  localparam logic [VAL_BITS-1:0] CONTOUR_RST = 16'hFFFF;
  localparam logic [VAL_BITS-1:0] BORDER_VAL  = 16'd1;

  // position flags of one pixel, worked out at accept time
  typedef struct packed {
    logic emit;       // input row is not the top row
    logic first_col;
    logic last_col;
    logic col1;
    logic col_w2;     // next column is the last one
    logic orow0;      // emitted row is the top row
    logic orow1;
    logic row_last;   // input row is the bottom row
    logic right_ok;
  } pos_flags_t;

endpackage

@@ hdl/lco_classify.sv @@
// Contour decision for one pixel of the window.
module lco_classify #(
  parameter int LABEL_BITS = lco_pkg::LABEL_BITS_DEF,
  parameter int PIXEL_BITS = lco_pkg::PIXEL_BITS_DEF
) (
  input  lco_pkg::pos_flags_t          flags_i,
  input  logic [LABEL_BITS-1:0]        mid_i,
  input  logic [LABEL_BITS-1:0]        up_i,
  input  logic [LABEL_BITS-1:0]        left_i,
  input  logic [LABEL_BITS-1:0]        right_i,
  input  logic [LABEL_BITS-1:0]        below_i,
  input  logic [PIXEL_BITS-1:0]        inten_i,
  input  logic [lco_pkg::VAL_BITS-1:0] contour_i,
  output logic [lco_pkg::VAL_BITS-1:0] val_o
);
  import lco_pkg::*;

  logic border;
  logic greater;
  logic near_ring;
  logic is_contour;

  assign border    = flags_i.orow0 || flags_i.first_col || flags_i.last_col;
  assign greater   = (mid_i > right_i) || (mid_i > below_i) ||
                     (mid_i > left_i) || (mid_i > up_i);
  assign near_ring = flags_i.col_w2 || flags_i.row_last || flags_i.col1 || flags_i.orow1;
  assign is_contour = (mid_i != '0) && (greater || near_ring);

  always_comb begin
    if (border) begin
      val_o = BORDER_VAL;
    end else if (is_contour && (contour_i != BORDER_VAL)) begin
      val_o = contour_i;
    end else begin
      val_o = VAL_BITS'(inten_i);
    end
  end

endmodule

@@ hdl/label_contour_overlay.sv @@
// Top level of the label contour overlay: counters, line buffers and output register.
// A pixel's result (for the row above) is registered in stage 1, then in the output register.
// Throughput: one pixel per cycle without stall; lab_prev_mem gives two reads, one write a cycle.
// An output stall holds the whole pipeline while an output is valid; input row 0 produces no transfer.
// Reset clears counters, valid flags, left hold and config (contour 65535, 2048 x 4096).
// Line buffers are not cleared; every entry is written before the next row reads it.
module label_contour_overlay #(
  parameter int MAX_WIDTH  = lco_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = lco_pkg::LABEL_BITS_DEF,
  parameter int PIXEL_BITS = lco_pkg::PIXEL_BITS_DEF,
  localparam int COL_W     = $clog2(MAX_WIDTH)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lco_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lco_pkg::VAL_BITS-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [LABEL_BITS-1:0]         label_i,
  input  logic [PIXEL_BITS-1:0]         intensity_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [lco_pkg::VAL_BITS-1:0]  pixel_value_o,
  output logic [lco_pkg::ROW_W-1:0]     out_row_o,
  output logic [COL_W-1:0]              out_column_o,
  output logic                          frame_done_o
);
  import lco_pkg::*;

  localparam int WX = (COL_W + 1 > FW_BITS) ? COL_W + 1 : FW_BITS;

  // configuration
  logic [VAL_BITS-1:0] contour_q;
  logic [FW_BITS-1:0]  fw_q;
  logic [FH_BITS-1:0]  fh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      contour_q <= CONTOUR_RST;
      fw_q      <= FW_BITS'(2048);
      fh_q      <= FH_BITS'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CONTOUR: contour_q <= cfg_wdata_i;
        CFG_WIDTH:   fw_q      <= cfg_wdata_i[FW_BITS-1:0];
        CFG_HEIGHT:  fh_q      <= cfg_wdata_i[FH_BITS-1:0];
        default: ;
      endcase
    end
  end

  logic [WX-1:0]      w_eff;
  logic [FH_BITS-1:0] h_eff;

  always_comb begin
    if (WX'(fw_q) < WX'(3)) begin
      w_eff = WX'(3);
    end else if (WX'(fw_q) > WX'(MAX_WIDTH)) begin
      w_eff = WX'(MAX_WIDTH);
    end else begin
      w_eff = WX'(fw_q);
    end
    if (fh_q < FH_BITS'(3)) begin
      h_eff = FH_BITS'(3);
    end else if (fh_q > FH_BITS'(MAX_HEIGHT)) begin
      h_eff = FH_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = fh_q;
    end
  end

  // handshake
  logic out_valid_q;
  logic advance;
  logic accept;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign accept     = in_valid_i && advance;

  // raster position
  logic [COL_W-1:0] col_q, col_d, col_c;
  logic [ROW_W-1:0] row_q, row_d, row_c;
  logic             restart;
  logic [WX-1:0]    col_inc;
  logic [FH_BITS-1:0] row_inc;
  pos_flags_t       flags;

  assign restart = (WX'(col_q) >= w_eff) || ({1'b0, row_q} >= h_eff);
  assign col_c   = restart ? '0 : col_q;
  assign row_c   = restart ? '0 : row_q;
  assign col_inc = WX'(col_c) + WX'(1);
  assign row_inc = {1'b0, row_c} + FH_BITS'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_inc >= w_eff) begin
        col_d = '0;
        row_d = (row_inc >= h_eff) ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_d = col_inc[COL_W-1:0];
        row_d = row_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    flags.emit      = (row_c != '0);
    flags.first_col = (col_c == '0);
    flags.last_col  = (col_inc == w_eff);
    flags.col1      = (col_c == COL_W'(1));
    flags.col_w2    = (WX'(col_c) + WX'(2) == w_eff);
    flags.orow0     = (row_c == ROW_W'(1));
    flags.orow1     = (row_c == ROW_W'(2));
    flags.row_last  = (row_inc == h_eff);
    flags.right_ok  = (col_inc < w_eff);
  end

  logic [COL_W-1:0] rd_right_addr;
  assign rd_right_addr = flags.right_ok ? col_inc[COL_W-1:0] : col_c;

  // stage 1: item in flight, memory read data arrives
  logic                  s1_valid_q;
  pos_flags_t            s1_flags_q;
  logic [COL_W-1:0]      s1_col_q;
  logic [ROW_W-1:0]      s1_row_q;
  logic [LABEL_BITS-1:0] s1_label_q;
  logic [PIXEL_BITS-1:0] s1_inten_q;
  logic [LABEL_BITS-1:0] up_q, mid_q, right_raw_q, left_hold_q;
  logic [PIXEL_BITS-1:0] inten_rd_q;
  logic                  wr_en;

  assign wr_en = advance && s1_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      left_hold_q <= '0;
    end else begin
      if (advance) s1_valid_q <= accept;
      if (wr_en) left_hold_q <= mid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_flags_q <= flags;
      s1_col_q   <= col_c;
      s1_row_q   <= row_c;
      s1_label_q <= label_i;
      s1_inten_q <= intensity_i;
    end
  end

  // line buffers: reads at accept, write-back when the item leaves stage 1
  logic [LABEL_BITS-1:0] lab_prev_mem  [MAX_WIDTH];
  logic [LABEL_BITS-1:0] lab_prev2_mem [MAX_WIDTH];
  logic [PIXEL_BITS-1:0] inten_mem     [MAX_WIDTH];

  always_ff @(posedge clk_i) begin
    if (wr_en) lab_prev_mem[s1_col_q] <= s1_label_q;
    if (accept) begin
      mid_q       <= lab_prev_mem[col_c];
      right_raw_q <= lab_prev_mem[rd_right_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) lab_prev2_mem[s1_col_q] <= mid_q;
    if (accept) up_q <= lab_prev2_mem[col_c];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) inten_mem[s1_col_q] <= s1_inten_q;
    if (accept) inten_rd_q <= inten_mem[col_c];
  end

  // pixel decision
  logic [LABEL_BITS-1:0] left_lab, right_lab;
  logic [VAL_BITS-1:0]   val;

  assign left_lab  = s1_flags_q.first_col ? mid_q : left_hold_q;
  assign right_lab = s1_flags_q.right_ok ? right_raw_q : '0;

  lco_classify #(
    .LABEL_BITS(LABEL_BITS),
    .PIXEL_BITS(PIXEL_BITS)
  ) u_classify (
    .flags_i  (s1_flags_q),
    .mid_i    (mid_q),
    .up_i     (up_q),
    .left_i   (left_lab),
    .right_i  (right_lab),
    .below_i  (s1_label_q),
    .inten_i  (inten_rd_q),
    .contour_i(contour_q),
    .val_o    (val)
  );

  // output register
  logic [VAL_BITS-1:0] pixel_q;
  logic [ROW_W-1:0]    orow_q;
  logic [COL_W-1:0]    ocol_q;
  logic                done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= s1_valid_q && s1_flags_q.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pixel_q <= val;
      orow_q  <= s1_row_q - ROW_W'(1);
      ocol_q  <= s1_col_q;
      done_q  <= s1_flags_q.row_last && s1_flags_q.last_col;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_value_o = pixel_q;
  assign out_row_o     = orow_q;
  assign out_column_o  = ocol_q;
  assign frame_done_o  = done_q;

endmodule

@@ test/lco_checker.sv @@
// Overlay checker: predicts each output pixel from the input transfers and compares results.
module lco_checker #(
  parameter int MAX_WIDTH = lco_pkg::MAX_WIDTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [lco_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [lco_pkg::VAL_BITS-1:0]       cfg_wdata_i,
  input  logic                               in_valid_i,
  input  logic                               in_stall_i,
  input  logic [lco_pkg::LABEL_BITS_DEF-1:0] label_i,
  input  logic [lco_pkg::PIXEL_BITS_DEF-1:0] intensity_i,
  input  logic                               out_valid_i,
  input  logic                               out_stall_i,
  input  logic [lco_pkg::VAL_BITS-1:0]       pixel_value_i,
  input  logic [lco_pkg::ROW_W-1:0]          out_row_i,
  input  logic [$clog2(MAX_WIDTH)-1:0]       out_column_i,
  input  logic                               frame_done_i,
  output int                                 mismatches_o,
  output int                                 pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import lco_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic [VAL_BITS-1:0] value;
    logic [ROW_W-1:0]    row;
    logic [COL_W-1:0]    col;
    logic                done;
  } overlay_px_t;

  // line buffers: labels one and two rows up, intensity one row up
  logic [LABEL_BITS_DEF-1:0] lab_above  [MAX_WIDTH];
  logic [LABEL_BITS_DEF-1:0] lab_above2 [MAX_WIDTH];
  logic [PIXEL_BITS_DEF-1:0] inten_above[MAX_WIDTH];
  logic [LABEL_BITS_DEF-1:0] west_hold;
  int unsigned               col_pos;
  int unsigned               row_pos;

  logic [VAL_BITS-1:0] contour_cfg;
  logic [FW_BITS-1:0]  width_cfg;
  logic [FH_BITS-1:0]  height_cfg;

  overlay_px_t overlay_due[$];

  task automatic take_pixel(input logic [LABEL_BITS_DEF-1:0] south,
                            input logic [PIXEL_BITS_DEF-1:0] inten);
    int unsigned               w, h, c, r;
    logic [LABEL_BITS_DEF-1:0] north, center, west, east;
    logic [PIXEL_BITS_DEF-1:0] pass;
    logic [VAL_BITS-1:0]       val;
    overlay_px_t               px;
    w = (width_cfg < 3) ? 3 : ((width_cfg > MAX_WIDTH) ? MAX_WIDTH : width_cfg);
    h = (height_cfg < 3) ? 3 : ((height_cfg > MAX_HEIGHT) ? MAX_HEIGHT : height_cfg);
    // geometry shrunk below the current position: a new frame starts here
    if (col_pos >= w || row_pos >= h) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;
    north  = lab_above2[c];
    center = lab_above[c];
    pass   = inten_above[c];
    west   = (c == 0) ? center : west_hold;
    east   = (c + 1 < w) ? lab_above[c + 1] : '0;
    if (r >= 1) begin
      val = BORDER_VAL;
      if (r != 1 && c != 0 && c != w - 1) begin
        if (center != 0 && (center > east || center > south || center > west ||
            center > north || c + 1 == w - 1 || r == h - 1 || c == 1 || r == 2))
          val = contour_cfg;
        if (val == BORDER_VAL) val = pass;
      end
      px.value = val;
      px.row   = ROW_W'(r - 1);
      px.col   = COL_W'(c);
      px.done  = (r == h - 1 && c == w - 1);
      overlay_due.push_back(px);
    end
    west_hold      = center;
    lab_above2[c]  = center;
    lab_above[c]   = south;
    inten_above[c] = inten;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;
  endtask

  task automatic report_bad(input string why, input overlay_px_t want,
                            input overlay_px_t seen);
    mismatches_o++;
    if (mismatches_o <= 10) begin
      $write("%0t overlay %s: want val %0d row %0d col %0d done %0b,",
             $time, why, want.value, want.row, want.col, want.done);
      $display(" got val %0d row %0d col %0d done %0b",
               seen.value, seen.row, seen.col, seen.done);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    overlay_px_t seen, want;
    if (!rst_ni) begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
        lab_above[i]   = '0;
        lab_above2[i]  = '0;
        inten_above[i] = '0;
      end
      west_hold    = '0;
      col_pos      = 0;
      row_pos      = 0;
      contour_cfg  = CONTOUR_RST;
      width_cfg    = FW_BITS'(MAX_WIDTH);
      height_cfg   = FH_BITS'(MAX_HEIGHT);
      overlay_due.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_CONTOUR: contour_cfg = cfg_wdata_i;
          CFG_WIDTH:   width_cfg   = cfg_wdata_i[FW_BITS-1:0];
          CFG_HEIGHT:  height_cfg  = cfg_wdata_i[FH_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) take_pixel(label_i, intensity_i);
      if (out_valid_i && !out_stall_i) begin
        seen = '{pixel_value_i, out_row_i, out_column_i, frame_done_i};
        if (overlay_due.size() == 0) begin
          report_bad("transfer with nothing due", '0, seen);
        end else begin
          want = overlay_due.pop_front();
          if (seen.value !== want.value || seen.row !== want.row ||
              seen.col !== want.col || seen.done !== want.done)
            report_bad("mismatch", want, seen);
        end
      end
      pending_o = overlay_due.size();
    end
  end

endmodule

@@ test/tb_label_contour_overlay.sv @@
// Stimulus and verdict for the label contour overlay block; checking lives in lco_checker.
module tb_label_contour_overlay;
  timeunit 1ns;
  timeprecision 1ps;
  import lco_pkg::*;

  localparam int COL_W       = $clog2(MAX_WIDTH_DEF);
  localparam int QUIET_LIMIT = 2000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;  // no register behind it

  typedef enum logic [1:0] {PAT_BLOBS, PAT_FEW, PAT_SPARSE, PAT_NOISE} pattern_e;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CFG_IDX_W-1:0]      cfg_idx;
  logic [VAL_BITS-1:0]       cfg_wdata;
  logic                      in_valid;
  logic                      in_stall;
  logic [LABEL_BITS_DEF-1:0] label;
  logic [PIXEL_BITS_DEF-1:0] intensity;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [VAL_BITS-1:0]       pixel_value;
  logic [ROW_W-1:0]          out_row;
  logic [COL_W-1:0]          out_column;
  logic                      frame_done;
  int                        mismatches;
  int                        pending;

  // stimulus state
  int       gap_max;
  int       stall_max;
  int       stall_left;
  bit       out_taken;
  int       quiet;
  int       fw = MAX_WIDTH_DEF;
  int       fh = MAX_HEIGHT;
  int       pos_r;
  int       pos_c;
  int       pixels_sent;
  bit       mid_frame;
  pattern_e pattern;
  int       blob_w;
  int       blob_h;
  int       blob_shift;

  logic [LABEL_BITS_DEF-1:0] blob_lut [5] = '{16'd0, 16'd1, 16'd2, 16'hFFFE, 16'hFFFF};

  // 5x5 probe frame: one fully interior pixel with equal neighbours, border-adjacent labels
  logic [LABEL_BITS_DEF-1:0] probe_label [25] = '{
    16'd0, 16'd0,     16'd0, 16'd0, 16'd0,
    16'd0, 16'hFFFF,  16'd3, 16'd3, 16'd0,
    16'd0, 16'd3,     16'd3, 16'd3, 16'd0,
    16'd0, 16'd3,     16'd3, 16'd0, 16'hFFFF,
    16'hFFFF, 16'd1,  16'd0, 16'd2, 16'd7};
  logic [PIXEL_BITS_DEF-1:0] probe_inten [25] = '{
    16'hFFFF, 16'd0, 16'd1, 16'd2, 16'd3,
    16'd4, 16'd0, 16'hFFFF, 16'd1, 16'd5,
    16'd6, 16'hFFFF, 16'd1, 16'd0, 16'd7,
    16'd8, 16'd9, 16'd10, 16'hFFFF, 16'd11,
    16'd12, 16'd13, 16'd14, 16'd15, 16'd16};

  label_contour_overlay DUT (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .label_i       (label),
    .intensity_i   (intensity),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_value_o (pixel_value),
    .out_row_o     (out_row),
    .out_column_o  (out_column),
    .frame_done_o  (frame_done)
  );

  lco_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .label_i       (label),
    .intensity_i   (intensity),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_value_i (pixel_value),
    .out_row_i     (out_row),
    .out_column_i  (out_column),
    .frame_done_i  (frame_done),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // output side: after each transfer, raise stall again for a random stretch bounded by stall_max
  always @(negedge clk) begin
    if (out_taken) stall_left = $urandom_range(stall_max, 0);
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_taken = out_valid && !out_stall;
  end

  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("tb_label_contour_overlay: errors");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // raw register code for an effective size; out-of-range codes clamp to the same size
  function automatic logic [VAL_BITS-1:0] geom_code(input int eff, input int ceiling,
                                                    input int bits);
    int unsigned mask, raw;
    mask = (1 << bits) - 1;
    if (eff <= 3) raw = $urandom_range(3, 0);
    else if (eff >= ceiling) raw = $urandom_range(mask, ceiling);
    else raw = eff;
    return VAL_BITS'(($urandom & ~mask) | raw);
  endfunction

  function automatic int pick_dim(input int big);
    if ($urandom_range(9, 0) == 0) return $urandom_range(big, 9);
    return $urandom_range(8, 3);
  endfunction

  function automatic int pick_idle();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 3;
      default: return 18;
    endcase
  endfunction

  function automatic logic [VAL_BITS-1:0] pick_contour();
    case ($urandom_range(5, 0))
      0:       return 16'd0;
      1:       return BORDER_VAL;
      2:       return 16'hFFFF;
      3:       return 16'd2;
      default: return VAL_BITS'($urandom);
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_BITS-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_geometry(input int w, input int h);
    write_reg(CFG_WIDTH, geom_code(w, MAX_WIDTH_DEF, FW_BITS));
    write_reg(CFG_HEIGHT, geom_code(h, MAX_HEIGHT, FH_BITS));
    fw        = w;
    fh        = h;
    pos_r     = 0;
    pos_c     = 0;
    mid_frame = 0;
  endtask

  task automatic new_pattern();
    pattern    = $urandom_range(1, 0) ? PAT_BLOBS : pattern_e'($urandom_range(3, 0));
    blob_w     = $urandom_range(4, 1);
    blob_h     = $urandom_range(4, 1);
    blob_shift = $urandom_range(4, 0);
  endtask

  task automatic send_pixel(input logic [LABEL_BITS_DEF-1:0] lab,
                            input logic [PIXEL_BITS_DEF-1:0] inten);
    int gap;
    gap = $urandom_range(gap_max, 0);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    label     <= lab;
    intensity <= inten;
    do @(posedge clk); while (in_stall);
    pixels_sent++;
    pos_c++;
    if (pos_c >= fw) begin
      pos_c = 0;
      pos_r++;
      if (pos_r >= fh) pos_r = 0;
    end
  endtask

  task automatic send_pixels(input int count);
    logic [LABEL_BITS_DEF-1:0] lab;
    logic [PIXEL_BITS_DEF-1:0] inten;
    repeat (count) begin
      case (pattern)
        PAT_BLOBS:
          lab = ($urandom_range(15, 0) == 0) ? LABEL_BITS_DEF'($urandom) :
                blob_lut[(pos_r / blob_h * 3 + pos_c / blob_w * 2 + blob_shift) % 5];
        PAT_FEW:    lab = LABEL_BITS_DEF'($urandom_range(3, 0));
        PAT_SPARSE: lab = ($urandom_range(4, 0) == 0) ? LABEL_BITS_DEF'($urandom) : '0;
        default:    lab = LABEL_BITS_DEF'($urandom);
      endcase
      case ($urandom_range(7, 0))
        0:       inten = '0;
        1:       inten = PIXEL_BITS_DEF'(1);
        2:       inten = '1;
        default: inten = PIXEL_BITS_DEF'($urandom);
      endcase
      send_pixel(lab, inten);
    end
  endtask

  // stop feeding, wait for every due pixel, then let the pipeline settle
  task automatic drain_block();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int w_new, h_new, stop_r, stop_c;
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = CFG_CONTOUR;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    label     = '0;
    intensity = '0;
    gap_max   = 2;
    stall_max = 2;
    new_pattern();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // a few pixels at reset geometry; the narrower width then forces a restart
    for (int i = 0; i < 5; i++) send_pixel(LABEL_BITS_DEF'(i * 16'h3333), PIXEL_BITS_DEF'(i));
    drain_block();
    set_geometry(5, 5);
    for (int i = 0; i < 25; i++) send_pixel(probe_label[i], probe_inten[i]);

    // the tallest frame, cut short by a height restart
    drain_block();
    gap_max   = 3;
    stall_max = 3;
    write_reg(CFG_CONTOUR, pick_contour());
    set_geometry(3, MAX_HEIGHT);
    new_pattern();
    send_pixels(3 * 40);
    mid_frame = 1;

    while (pixels_sent < 1900) begin
      drain_block();
      gap_max   = pick_idle();
      stall_max = pick_idle();
      if ($urandom_range(1, 0)) write_reg(CFG_CONTOUR, pick_contour());
      if ($urandom_range(7, 0) == 0) write_reg(CFG_SPARE, VAL_BITS'($urandom));
      w_new = pick_dim(64);
      h_new = pick_dim(20);
      // leaving a frame partway: new size must fall at or below the current position
      if (mid_frame) begin
        if (pos_c >= 3) w_new = $urandom_range(pos_c < 12 ? pos_c : 12, 3);
        else h_new = $urandom_range(pos_r < 12 ? pos_r : 12, 3);
      end
      set_geometry(w_new, h_new);
      repeat ($urandom_range(2, 1)) begin
        new_pattern();
        send_pixels(fw * fh);
      end
      if ((fw > 3 || fh > 3) && $urandom_range(3, 0) == 0) begin
        new_pattern();
        if (fw > 3) begin
          stop_r = $urandom_range(fh - 1, 0);
          stop_c = $urandom_range(fw - 1, 3);
        end else begin
          stop_r = $urandom_range(fh - 1, 3);
          stop_c = $urandom_range(fw - 1, 0);
        end
        send_pixels(stop_r * fw + stop_c);
        mid_frame = 1;
      end
    end

    drain_block();
    if (mismatches == 0 && pending == 0) begin
      $display("tb_label_contour_overlay: clean");
    end else begin
      $display("tb_label_contour_overlay: errors");
    end
    $finish;
  end

endmodule
